@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge, disabled while reset is asserted.
`define PFI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PFI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PFI_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFI_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hw/rtl/pfi_pkg.sv @@
// ----------------------------------------------------------------------------
// Packet fault injector package
// Register map, action codes and the per-channel settings type.
// ----------------------------------------------------------------------------
package pfi_pkg;

    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned APB_DW   = 64;
    localparam int unsigned APB_AW   = 5;
    localparam int unsigned SET_W    = 48;
    localparam int unsigned NUM_CH   = 3;

    // register index, paddr[4:3]
    localparam logic [1:0] REG_ENABLE     = 2'd0;
    localparam logic [1:0] REG_LOSS       = 2'd1;
    localparam logic [1:0] REG_CORRUPT    = 2'd2;
    localparam logic [1:0] REG_REPLY_LOSS = 2'd3;

    // enable mask bits
    localparam int unsigned EN_LOSS    = 0;
    localparam int unsigned EN_CORRUPT = 1;
    localparam int unsigned EN_REPLY   = 2;

    // event kinds
    localparam logic KIND_OUTGOING = 1'b0;
    localparam logic KIND_INCOMING = 1'b1;

    // result codes
    localparam logic [1:0] ACT_PASS     = 2'd0;
    localparam logic [1:0] ACT_DROP     = 2'd1;
    localparam logic [1:0] ACT_CORRUPT  = 2'd2;
    localparam logic [1:0] ACT_SUPPRESS = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] cap;
        logic [FIELD_W-1:0] run_len;
        logic [FIELD_W-1:0] interval;
    } chan_cfg_t;

endpackage

@@ hw/rtl/pfi_stream_if.sv @@
// ----------------------------------------------------------------------------
// Packet fault injector stream interfaces
// Valid/ready channels for packet events and fault actions.
// ----------------------------------------------------------------------------
interface pfi_evt_if;
    logic valid;
    logic ready;
    logic event_kind;

    modport source (output valid, output event_kind, input ready);
    modport sink   (input valid, input event_kind, output ready);
endinterface

interface pfi_act_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;

    modport source (output valid, output action, input ready);
    modport sink   (input valid, input action, output ready);
endinterface

@@ hw/rtl/pfi_regs.sv @@
// ----------------------------------------------------------------------------
// Packet fault injector register file
// APB-style settings registers; any write raises a one-cycle counter clear.
// ----------------------------------------------------------------------------
module pfi_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfi_pkg::APB_AW-1:0] paddr,
    input  logic [pfi_pkg::APB_DW-1:0] pwdata,
    output logic [pfi_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [2:0]                 enable_mask,
    output pfi_pkg::chan_cfg_t         loss_cfg,
    output pfi_pkg::chan_cfg_t         corrupt_cfg,
    output pfi_pkg::chan_cfg_t         reply_cfg,
    output logic                       cfg_clear
);
    import pfi_pkg::*;

    logic [2:0]       enable_reg;
    logic [SET_W-1:0] loss_reg;
    logic [SET_W-1:0] corrupt_reg;
    logic [SET_W-1:0] reply_reg;
    logic [1:0]       reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= '0;
            loss_reg    <= '0;
            corrupt_reg <= '0;
            reply_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ENABLE:     enable_reg  <= pwdata[2:0];
                REG_LOSS:       loss_reg    <= pwdata[SET_W-1:0];
                REG_CORRUPT:    corrupt_reg <= pwdata[SET_W-1:0];
                REG_REPLY_LOSS: reply_reg   <= pwdata[SET_W-1:0];
                default:        enable_reg  <= enable_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ENABLE:     prdata = {{(APB_DW-3){1'b0}}, enable_reg};
            REG_LOSS:       prdata = {{(APB_DW-SET_W){1'b0}}, loss_reg};
            REG_CORRUPT:    prdata = {{(APB_DW-SET_W){1'b0}}, corrupt_reg};
            REG_REPLY_LOSS: prdata = {{(APB_DW-SET_W){1'b0}}, reply_reg};
            default:        prdata = '0;
        endcase
    end

    assign enable_mask = enable_reg;
    assign loss_cfg    = chan_cfg_t'(loss_reg);
    assign corrupt_cfg = chan_cfg_t'(corrupt_reg);
    assign reply_cfg   = chan_cfg_t'(reply_reg);
    assign cfg_clear   = wr_en;

endmodule

@@ hw/rtl/pfi_chan.sv @@
// ----------------------------------------------------------------------------
// Packet fault injector channel
// Gap, run and applied-total counters of one fault channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfi_chan #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pfi_pkg::chan_cfg_t cfg,
    input  logic               enable,
    input  logic               clear,
    input  logic               check,
    output logic               fire
);
    import pfi_pkg::*;

    localparam int unsigned CMP_W = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] gap_reg,     gap_next;
    logic [COUNT_WIDTH-1:0] run_reg,     run_next;
    logic [COUNT_WIDTH-1:0] applied_reg, applied_next;
    logic [COUNT_WIDTH-1:0] gap_inc;
    logic [COUNT_WIDTH-1:0] applied_inc;
    logic [COUNT_WIDTH-1:0] run_load;
    logic [FIELD_W-1:0]     rest;
    logic                   eligible;
    logic                   in_run;
    logic                   gap_hit;

    assign gap_inc     = (gap_reg == CNT_MAX) ? gap_reg : gap_reg + 1'b1;
    assign applied_inc = (applied_reg == CNT_MAX) ? applied_reg : applied_reg + 1'b1;
    assign rest        = (cfg.run_len == '0) ? '0 : cfg.run_len - 1'b1;
    assign run_load    = (CMP_W'(rest) > CMP_W'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(rest);

    assign eligible = enable && (CMP_W'(applied_reg) < CMP_W'(cfg.cap));
    assign in_run   = (run_reg != '0);
    assign gap_hit  = (CMP_W'(gap_inc) >= CMP_W'(cfg.interval));
    assign fire     = eligible && (in_run || gap_hit);

    always_comb
    begin
        gap_next     = gap_reg;
        run_next     = run_reg;
        applied_next = applied_reg;
        if (clear)
        begin
            gap_next     = '0;
            run_next     = '0;
            applied_next = '0;
        end
        else if (check && eligible)
        begin
            if (in_run)
            begin
                run_next     = run_reg - 1'b1;
                applied_next = applied_inc;
            end
            else if (gap_hit)
            begin
                run_next     = run_load;
                gap_next     = '0;
                applied_next = applied_inc;
            end
            else
            begin
                gap_next = gap_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg     <= '0;
            run_reg     <= '0;
            applied_reg <= '0;
        end
        else
        begin
            gap_reg     <= gap_next;
            run_reg     <= run_next;
            applied_reg <= applied_next;
        end
    end

    `PFI_ASSERT(a_clear_zeroes, clk, rst_n, clear |=> (gap_reg == '0 && run_reg == '0 && applied_reg == '0), "counters not cleared after write")
    `PFI_ASSERT(a_total_monotonic, clk, rst_n, !clear |=> (applied_reg >= $past(applied_reg)), "applied total decreased without clear")
    `PFI_ASSERT(a_total_capped, clk, rst_n, CMP_W'(applied_reg) <= CMP_W'(cfg.cap), "applied total above cap")

endmodule

@@ hw/rtl/packet_fault_injector.sv @@
// ----------------------------------------------------------------------------
// Packet fault injector
// Per packet event, picks pass, drop, corrupt or suppress-reply.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  evt     | in  | valid/ready  | event_kind (1b)
//  act     | out | valid/ready  | action (2b)
//  apb     | in  | psel/penable | 64b data, paddr[4:3] = register index
//
//  One event per cycle while the result register is empty or act.ready is high;
//  the action is held in the single result register after the counter logic.
//  evt.ready stays high while the result register is empty or being taken.
//  rst_n clears all settings and counters; any register write clears counters.
// ----------------------------------------------------------------------------
module packet_fault_injector #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    pfi_evt_if.sink                    evt,
    pfi_act_if.source                  act,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfi_pkg::APB_AW-1:0] paddr,
    input  logic [pfi_pkg::APB_DW-1:0] pwdata,
    output logic [pfi_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import pfi_pkg::*;

    logic [2:0] enable_mask;
    chan_cfg_t  loss_cfg;
    chan_cfg_t  corrupt_cfg;
    chan_cfg_t  reply_cfg;
    logic       cfg_clear;

    logic       evt_acc;
    logic       loss_fire, corrupt_fire, reply_fire;
    logic       loss_check, corrupt_check, reply_check;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] action_reg, action_next;

    pfi_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .enable_mask (enable_mask),
        .loss_cfg    (loss_cfg),
        .corrupt_cfg (corrupt_cfg),
        .reply_cfg   (reply_cfg),
        .cfg_clear   (cfg_clear)
    );

    assign evt.ready = !out_valid_reg || act.ready;
    assign evt_acc   = evt.valid && evt.ready;

    assign loss_check    = evt_acc && (evt.event_kind == KIND_OUTGOING);
    assign corrupt_check = loss_check && !loss_fire;
    assign reply_check   = evt_acc && (evt.event_kind == KIND_INCOMING);

    pfi_chan #(.COUNT_WIDTH(COUNT_WIDTH)) u_loss (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (loss_cfg),
        .enable (enable_mask[EN_LOSS]),
        .clear  (cfg_clear),
        .check  (loss_check),
        .fire   (loss_fire)
    );

    pfi_chan #(.COUNT_WIDTH(COUNT_WIDTH)) u_corrupt (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (corrupt_cfg),
        .enable (enable_mask[EN_CORRUPT]),
        .clear  (cfg_clear),
        .check  (corrupt_check),
        .fire   (corrupt_fire)
    );

    pfi_chan #(.COUNT_WIDTH(COUNT_WIDTH)) u_reply (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (reply_cfg),
        .enable (enable_mask[EN_REPLY]),
        .clear  (cfg_clear),
        .check  (reply_check),
        .fire   (reply_fire)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        action_next    = action_reg;
        if (evt_acc)
        begin
            out_valid_next = 1'b1;
            if (evt.event_kind == KIND_OUTGOING)
            begin
                if (loss_fire)
                    action_next = ACT_DROP;
                else if (corrupt_fire)
                    action_next = ACT_CORRUPT;
                else
                    action_next = ACT_PASS;
            end
            else
            begin
                action_next = reply_fire ? ACT_SUPPRESS : ACT_PASS;
            end
        end
        else if (act.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
    end

    assign act.valid  = out_valid_reg;
    assign act.action = action_reg;

endmodule
